// ----- hdl/pvf_pkg.sv -----
// shared types and constants for the polyhedron volume block
// no dependencies
`default_nettype none

package pvf_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int COORD_BITS   = 16;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = VIDX_W + 1;
    localparam int SUM_W        = COORD_BITS + VIDX_W + 1;
    localparam int D_W          = COORD_BITS + 1;
    localparam int P_W          = 2 * D_W;
    localparam int N_W          = P_W + 1;
    localparam int M_W          = N_W + D_W;
    localparam int T_W          = M_W + 2;
    localparam int VOL_W        = 63;

    localparam logic OP_VERTEX = 1'b0;
    localparam logic OP_FACET  = 1'b1;

    localparam logic [VOL_W-1:0] VOL_MAX = '1;

    typedef struct packed {
        logic                         operation;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
        logic [VIDX_W-1:0]            corner_a;
        logic [VIDX_W-1:0]            corner_b;
        logic [VIDX_W-1:0]            corner_c;
        logic                         final_facet;
    } pvf_in_t;

    typedef struct packed {
        logic [VOL_W-1:0] cell_volume;
        logic             bad_index;
    } pvf_out_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } pvf_vec_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] x;
        logic signed [SUM_W-1:0] y;
        logic signed [SUM_W-1:0] z;
    } pvf_sum_t;

endpackage

`default_nettype wire

// ----- hdl/pvf_cdiv.sv -----
// iterative centroid divider: three coordinate sums by the vertex count
// depends on pvf_pkg
`default_nettype none

module pvf_cdiv (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire pvf_pkg::pvf_sum_t sums,
    input  wire logic [pvf_pkg::CNT_W-1:0] count,
    output logic                 done,
    output pvf_pkg::pvf_vec_t    quot
);
    import pvf_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic [SUM_W-1:0]  dvd_reg [3];
    logic [SUM_W-1:0]  quo_reg [3];
    logic [CNT_W-1:0]  rem_reg [3];
    logic              neg_reg [3];
    logic [CNT_W-1:0]  div_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic signed [SUM_W-1:0] sum_a [3];
    logic [SUM_W-1:0]        mag_a [3];
    logic [CNT_W:0]          trial [3];
    logic [CNT_W-1:0]        rem_next [3];
    logic                    qbit [3];
    logic [SUM_W-1:0]        q_fix [3];

    always_comb
    begin
        sum_a[0] = sums.x;
        sum_a[1] = sums.y;
        sum_a[2] = sums.z;
        for (int k = 0; k < 3; k++)
        begin
            mag_a[k] = sum_a[k][SUM_W-1] ? SUM_W'(-sum_a[k]) : SUM_W'(sum_a[k]);
            trial[k] = {rem_reg[k], dvd_reg[k][SUM_W-1]};
            if (trial[k] >= {1'b0, div_reg})
            begin
                rem_next[k] = CNT_W'(trial[k] - {1'b0, div_reg});
                qbit[k]     = 1'b1;
            end
            else
            begin
                rem_next[k] = trial[k][CNT_W-1:0];
                qbit[k]     = 1'b0;
            end
            q_fix[k] = neg_reg[k] ? SUM_W'(-quo_reg[k]) : quo_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= count;
            for (int k = 0; k < 3; k++)
            begin
                dvd_reg[k] <= mag_a[k];
                quo_reg[k] <= '0;
                rem_reg[k] <= '0;
                neg_reg[k] <= sum_a[k][SUM_W-1];
            end
        end
        else if (busy_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                dvd_reg[k] <= {dvd_reg[k][SUM_W-2:0], 1'b0};
                quo_reg[k] <= {quo_reg[k][SUM_W-2:0], qbit[k]};
                rem_reg[k] <= rem_next[k];
            end
        end
    end

    assign done   = done_reg;
    assign quot.x = q_fix[0][COORD_BITS-1:0];
    assign quot.y = q_fix[1][COORD_BITS-1:0];
    assign quot.z = q_fix[2][COORD_BITS-1:0];

endmodule

`default_nettype wire

// ----- hdl/pvf_term.sv -----
// one tetrahedron term: triple product against the centroid, then |t| / 6
// depends on pvf_pkg
`default_nettype none

module pvf_term (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire pvf_pkg::pvf_vec_t pa,
    input  wire pvf_pkg::pvf_vec_t pb,
    input  wire pvf_pkg::pvf_vec_t pc,
    input  wire pvf_pkg::pvf_vec_t cen,
    output logic               done,
    output logic [pvf_pkg::T_W-1:0] term
);
    import pvf_pkg::*;

    localparam int DIV_STEPS = (T_W + 7) / 8;
    localparam int DV_W      = DIV_STEPS * 8;
    localparam int DC_W      = $clog2(DIV_STEPS + 1);

    logic signed [P_W-1:0] p_reg [6];
    logic signed [D_W-1:0] w_reg [3];
    logic signed [M_W-1:0] m_reg [3];
    logic [DV_W-1:0]       dvd_reg;
    logic [DV_W-1:0]       quo_reg;
    logic [2:0]            rem_reg;
    logic                  v1_reg;
    logic                  v2_reg;
    logic                  busy_reg;
    logic [DC_W-1:0]       cnt_reg;
    logic                  done_reg;

    logic signed [D_W-1:0] ea [3];
    logic signed [D_W-1:0] eb [3];
    logic signed [D_W-1:0] ec [3];
    logic signed [D_W-1:0] ed [3];
    logic signed [D_W-1:0] u [3];
    logic signed [D_W-1:0] v [3];
    logic signed [N_W-1:0] n [3];
    logic signed [T_W-1:0] t_sum;
    logic [T_W-1:0]        t_mag;
    logic [3:0]            r4;
    logic [2:0]            rem_step;
    logic [7:0]            qbyte;

    always_comb
    begin
        ea[0] = D_W'(pa.x); ea[1] = D_W'(pa.y); ea[2] = D_W'(pa.z);
        eb[0] = D_W'(pb.x); eb[1] = D_W'(pb.y); eb[2] = D_W'(pb.z);
        ec[0] = D_W'(pc.x); ec[1] = D_W'(pc.y); ec[2] = D_W'(pc.z);
        ed[0] = D_W'(cen.x); ed[1] = D_W'(cen.y); ed[2] = D_W'(cen.z);
        for (int k = 0; k < 3; k++)
        begin
            u[k] = eb[k] - ea[k];
            v[k] = ec[k] - ea[k];
        end
        n[0] = N_W'(p_reg[0]) - N_W'(p_reg[1]);
        n[1] = N_W'(p_reg[2]) - N_W'(p_reg[3]);
        n[2] = N_W'(p_reg[4]) - N_W'(p_reg[5]);
        t_sum = T_W'(m_reg[0]) + T_W'(m_reg[1]) + T_W'(m_reg[2]);
        t_mag = t_sum[T_W-1] ? T_W'(-t_sum) : T_W'(t_sum);
        rem_step = rem_reg;
        qbyte    = '0;
        for (int i = 0; i < 8; i++)
        begin
            r4 = {rem_step, dvd_reg[DV_W-1-i]};
            if (r4 >= 4'd6)
            begin
                rem_step     = 3'(r4 - 4'd6);
                qbyte[7-i]   = 1'b1;
            end
            else
            begin
                rem_step = r4[2:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            done_reg <= 1'b0;
            if (v2_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == DC_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            p_reg[0] <= P_W'(u[1]) * P_W'(v[2]);
            p_reg[1] <= P_W'(u[2]) * P_W'(v[1]);
            p_reg[2] <= P_W'(u[2]) * P_W'(v[0]);
            p_reg[3] <= P_W'(u[0]) * P_W'(v[2]);
            p_reg[4] <= P_W'(u[0]) * P_W'(v[1]);
            p_reg[5] <= P_W'(u[1]) * P_W'(v[0]);
            for (int k = 0; k < 3; k++)
                w_reg[k] <= ed[k] - ea[k];
        end
        if (v1_reg)
        begin
            for (int k = 0; k < 3; k++)
                m_reg[k] <= M_W'(n[k]) * M_W'(w_reg[k]);
        end
        if (v2_reg)
        begin
            dvd_reg <= DV_W'(t_mag);
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DV_W-9:0], 8'd0};
            quo_reg <= {quo_reg[DV_W-9:0], qbyte};
            rem_reg <= rem_step;
        end
    end

    assign done = done_reg;
    assign term = quo_reg[T_W-1:0];

endmodule

`default_nettype wire

// ----- hdl/polyhedron_volume_from_facets.sv -----
// top level: vertex memory, cell state, facet sequencer and result register
// depends on pvf_pkg, pvf_cdiv, pvf_term
//
// usage: items arrive on the item channel (valid/stall). a vertex item is
// written to the vertex memory and summed when it is accepted; vertices past
// the memory depth are dropped. a facet item reads its three corners from
// the read port of the vertex memory one per cycle, then a pipelined triple
// product (2 multiply stages) and a byte-per-cycle divide by 6 form the term.
// the first facet of a cell that holds vertices also runs the bit-serial
// centroid divider. a facet with an out-of-range corner goes straight to the
// done state and adds nothing. one item is in work at a time; item_stall is
// high while a facet is in work.
// the final facet of a cell places volume and error flag in the result
// register and clears the cell state; a result waits there while
// result_stall is high, and vertex loads keep flowing meanwhile. a later
// final facet holds in its last state until the register is free.
// reset clears all cell state and the result valid flag; memory contents are
// undefined until written.
`default_nettype none

module polyhedron_volume_from_facets (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire pvf_pkg::pvf_in_t item,
    output logic             result_valid,
    input  wire logic        result_stall,
    output pvf_pkg::pvf_out_t result
);
    import pvf_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CDIV  = 8'b0000_0010,
        S_CHECK = 8'b0000_0100,
        S_RA    = 8'b0000_1000,
        S_RB    = 8'b0001_0000,
        S_RC    = 8'b0010_0000,
        S_CALC  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  vcnt_reg;
    pvf_sum_t          sum_reg;
    pvf_vec_t          cen_reg;
    logic              cen_ok_reg;
    logic [VOL_W-1:0]  acc_reg;
    logic              err_reg;
    pvf_in_t           fac_reg;
    pvf_vec_t          pa_reg;
    pvf_vec_t          pb_reg;
    logic              out_valid_reg;
    pvf_out_t          out_reg;

    logic [3*COORD_BITS-1:0] mem [MAX_VERTICES];
    logic [3*COORD_BITS-1:0] rd_data_reg;
    logic [VIDX_W-1:0]       rd_addr;
    pvf_vec_t                rd_vec;

    logic              accept;
    logic              load_ok;
    logic              cdiv_start;
    logic              cdiv_done;
    pvf_vec_t          cdiv_quot;
    logic              term_done;
    logic [T_W-1:0]    term;
    logic              bad;
    logic [VOL_W:0]    acc_sum;
    logic              out_free;

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;
    assign load_ok    = accept && (item.operation == OP_VERTEX)
                        && (vcnt_reg < CNT_W'(MAX_VERTICES));
    assign cdiv_start = accept && (item.operation == OP_FACET)
                        && !cen_ok_reg && (vcnt_reg != '0);
    assign bad = ({1'b0, fac_reg.corner_a} >= vcnt_reg)
              || ({1'b0, fac_reg.corner_b} >= vcnt_reg)
              || ({1'b0, fac_reg.corner_c} >= vcnt_reg);
    assign acc_sum  = {1'b0, acc_reg} + (VOL_W + 1)'(term);
    assign out_free = !out_valid_reg || !result_stall;
    assign rd_vec   = rd_data_reg;

    always_comb
    begin
        case (state_reg)
            S_CHECK: rd_addr = fac_reg.corner_a;
            S_RA:    rd_addr = fac_reg.corner_b;
            default: rd_addr = fac_reg.corner_c;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_ok)
            mem[vcnt_reg[VIDX_W-1:0]] <= {item.coord_x, item.coord_y, item.coord_z};
        rd_data_reg <= mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && item.operation == OP_FACET)
                    state_next = cdiv_start ? S_CDIV : S_CHECK;
            end
            S_CDIV:  if (cdiv_done) state_next = S_CHECK;
            S_CHECK: state_next = bad ? S_DONE : S_RA;
            S_RA:    state_next = S_RB;
            S_RB:    state_next = S_RC;
            S_RC:    state_next = S_CALC;
            S_CALC:  if (term_done) state_next = S_DONE;
            S_DONE:  if (!fac_reg.final_facet || out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vcnt_reg      <= '0;
            sum_reg       <= '0;
            cen_reg       <= '0;
            cen_ok_reg    <= 1'b0;
            acc_reg       <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && fac_reg.final_facet && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !result_stall)
                out_valid_reg <= 1'b0;
            if (load_ok)
            begin
                vcnt_reg  <= vcnt_reg + 1'b1;
                sum_reg.x <= sum_reg.x + SUM_W'(item.coord_x);
                sum_reg.y <= sum_reg.y + SUM_W'(item.coord_y);
                sum_reg.z <= sum_reg.z + SUM_W'(item.coord_z);
            end
            if (accept && item.operation == OP_FACET && !cen_ok_reg && vcnt_reg == '0)
            begin
                cen_reg    <= '0;
                cen_ok_reg <= 1'b1;
            end
            if (state_reg == S_CDIV && cdiv_done)
            begin
                cen_reg    <= cdiv_quot;
                cen_ok_reg <= 1'b1;
            end
            if (state_reg == S_CHECK && bad)
                err_reg <= 1'b1;
            if (state_reg == S_CALC && term_done)
                acc_reg <= acc_sum[VOL_W] ? VOL_MAX : acc_sum[VOL_W-1:0];
            if (state_reg == S_DONE && fac_reg.final_facet && out_free)
            begin
                vcnt_reg      <= '0;
                sum_reg       <= '0;
                cen_reg       <= '0;
                cen_ok_reg    <= 1'b0;
                acc_reg       <= '0;
                err_reg       <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && item.operation == OP_FACET)
            fac_reg <= item;
        if (state_reg == S_RA)
            pa_reg <= rd_vec;
        if (state_reg == S_RB)
            pb_reg <= rd_vec;
        if (state_reg == S_DONE && fac_reg.final_facet && out_free)
        begin
            out_reg.cell_volume <= acc_reg;
            out_reg.bad_index   <= err_reg;
        end
    end

    pvf_cdiv u_cdiv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cdiv_start),
        .sums  (sum_reg),
        .count (vcnt_reg),
        .done  (cdiv_done),
        .quot  (cdiv_quot)
    );

    pvf_term u_term (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == S_RC),
        .pa    (pa_reg),
        .pb    (pb_reg),
        .pc    (rd_vec),
        .cen   (cen_reg),
        .done  (term_done),
        .term  (term)
    );

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state register not one-hot");
    a_vcnt: assert property (@(posedge clk) disable iff (!rst_n)
        vcnt_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count past memory depth");
    a_cdiv: assert property (@(posedge clk) disable iff (!rst_n)
        cdiv_done |-> state_reg == S_CDIV)
        else $error("centroid divider finished outside its state");
    a_facet: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.operation == OP_FACET |=> item_stall)
        else $error("facet transfer did not start the sequencer");

endmodule

`default_nettype wire

// ----- sim/polyhedron_volume_from_facets_test.sv -----
// testbench for polyhedron_volume_from_facets: directed, full store, random cells
// checks each result against an in-bench volume predictor; depends on pvf_pkg
`timescale 1ns / 100ps

module polyhedron_volume_from_facets_test;
    import pvf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 64;

    typedef struct {
        pvf_in_t  stim;
        bit       typed;
        pvf_out_t want;
    } table_row_t;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    pvf_in_t     item;
    logic        result_valid;
    logic        result_stall;
    pvf_out_t    result;

    // predictor state
    longint store_x [MAX_VERTICES];
    longint store_y [MAX_VERTICES];
    longint store_z [MAX_VERTICES];
    int     nverts;
    longint acc_x, acc_y, acc_z;
    longint cen_x, cen_y, cen_z;
    bit     cen_fixed;
    bit [VOL_W-1:0] vol_acc;
    bit     idx_err;

    pvf_out_t volume_queue[$];
    bit       typed_queue[$];
    pvf_out_t typed_want[$];
    table_row_t directed[$];
    int     failures;
    int     idle_count;
    bit     stim_done;
    bit     drain_quiet;
    bit     hold_off;

    polyhedron_volume_from_facets DUT (
        .clk(clk), .rst_n(rst_n),
        .item_valid(item_valid), .item_stall(item_stall), .item(item),
        .result_valid(result_valid), .result_stall(result_stall), .result(result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit [VOL_W-1:0] sixth_of_abs(longint hi, longint lo);
        logic signed [127:0] t;
        logic [127:0] q;
        t = (128'(signed'(hi)) <<< 32) + 128'(signed'(lo));
        if (t < 0)
            t = -t;
        q = t / 6;
        if (q > 128'(VOL_MAX))
            return VOL_MAX;
        return q[VOL_W-1:0];
    endfunction

    function automatic void clear_cell();
        nverts = 0;
        acc_x = 0; acc_y = 0; acc_z = 0;
        cen_x = 0; cen_y = 0; cen_z = 0;
        cen_fixed = 0;
        vol_acc = 0;
        idx_err = 0;
    endfunction

    // returns 1 when the item yields a cell result
    function automatic bit predict_volume(pvf_in_t it, output pvf_out_t res);
        longint ux, uy, uz, vx, vy, vz, wx, wy, wz, nx, ny, nz;
        bit [VOL_W-1:0] term;
        res = '0;
        if (it.operation == OP_VERTEX)
        begin
            if (nverts < MAX_VERTICES)
            begin
                store_x[nverts] = longint'(it.coord_x);
                store_y[nverts] = longint'(it.coord_y);
                store_z[nverts] = longint'(it.coord_z);
                acc_x += longint'(it.coord_x);
                acc_y += longint'(it.coord_y);
                acc_z += longint'(it.coord_z);
                nverts++;
            end
            return 0;
        end
        if (!cen_fixed)
        begin
            if (nverts > 0)
            begin
                cen_x = acc_x / longint'(nverts);
                cen_y = acc_y / longint'(nverts);
                cen_z = acc_z / longint'(nverts);
            end
            cen_fixed = 1;
        end
        if (int'(it.corner_a) >= nverts || int'(it.corner_b) >= nverts
            || int'(it.corner_c) >= nverts)
            idx_err = 1;
        else
        begin
            ux = store_x[it.corner_b] - store_x[it.corner_a];
            uy = store_y[it.corner_b] - store_y[it.corner_a];
            uz = store_z[it.corner_b] - store_z[it.corner_a];
            vx = store_x[it.corner_c] - store_x[it.corner_a];
            vy = store_y[it.corner_c] - store_y[it.corner_a];
            vz = store_z[it.corner_c] - store_z[it.corner_a];
            wx = cen_x - store_x[it.corner_a];
            wy = cen_y - store_y[it.corner_a];
            wz = cen_z - store_z[it.corner_a];
            nx = uy * vz - uz * vy;
            ny = uz * vx - ux * vz;
            nz = ux * vy - uy * vx;
            // split products to stay exact
            term = sixth_of_abs((nx >>> 32) * wx + (ny >>> 32) * wy + (nz >>> 32) * wz,
                (nx & 64'hFFFF_FFFF) * wx + (ny & 64'hFFFF_FFFF) * wy
                + (nz & 64'hFFFF_FFFF) * wz);
            if (term > VOL_MAX - vol_acc)
                vol_acc = VOL_MAX;
            else
                vol_acc += term;
        end
        if (it.final_facet)
        begin
            res.cell_volume = vol_acc;
            res.bad_index = idx_err;
            clear_cell();
            return 1;
        end
        return 0;
    endfunction

    function automatic pvf_in_t make_vertex(int x, int y, int z, bit fin);
        pvf_in_t it;
        it = '0;
        it.operation = OP_VERTEX;
        it.coord_x = COORD_BITS'(x);
        it.coord_y = COORD_BITS'(y);
        it.coord_z = COORD_BITS'(z);
        it.corner_a = VIDX_W'($urandom);
        it.corner_b = VIDX_W'($urandom);
        it.corner_c = VIDX_W'($urandom);
        it.final_facet = fin;
        return it;
    endfunction

    function automatic pvf_in_t make_facet(int a, int b, int c, bit fin);
        pvf_in_t it;
        it = '0;
        it.operation = OP_FACET;
        it.coord_x = COORD_BITS'($urandom);
        it.coord_y = COORD_BITS'($urandom);
        it.coord_z = COORD_BITS'($urandom);
        it.corner_a = VIDX_W'(a);
        it.corner_b = VIDX_W'(b);
        it.corner_c = VIDX_W'(c);
        it.final_facet = fin;
        return it;
    endfunction

    task automatic add_row(pvf_in_t it, bit typed, pvf_out_t want);
        table_row_t r;
        r.stim = it; r.typed = typed; r.want = want;
        directed = {directed, r};
    endtask

    task automatic gap_cycles();
        int n;
        if (!drain_quiet && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 13);
            item_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_item(pvf_in_t it, bit typed, pvf_out_t want);
        pvf_out_t res;
        gap_cycles();
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        if (predict_volume(it, res))
        begin
            volume_queue = {volume_queue, res};
            typed_queue = {typed_queue, typed};
            typed_want = {typed_want, want};
        end
    endtask

    task automatic send_vertex_rand(int span);
        int x, y, z;
        x = $urandom_range(0, 2 * span) - span;
        y = $urandom_range(0, 2 * span) - span;
        z = $urandom_range(0, 2 * span) - span;
        send_item(make_vertex(x, y, z, $urandom_range(0, 7) == 0), 0, '0);
    endtask

    task automatic send_facet_rand(int nv, bit fin);
        int a, b, c, top;
        top = (nv > 0) ? nv - 1 : 0;
        if ($urandom_range(0, 15) == 0)
            top = 63;
        a = $urandom_range(0, top); b = $urandom_range(0, top); c = $urandom_range(0, top);
        send_item(make_facet(a, b, c, fin), 0, '0);
    endtask

    // stimulus
    initial
    begin
        pvf_out_t none_res;
        pvf_out_t w;
        int cells, nv, nf, span, k;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        stim_done = 0;
        drain_quiet = 0;
        failures = 0;
        clear_cell();
        none_res = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty cell: bad index, zero volume
        w.cell_volume = '0; w.bad_index = 1'b1;
        add_row(make_facet(0, 0, 0, 1), 1, w);
        // tetra at coordinate extremes, degenerate facet
        add_row(make_vertex(0, 0, 0, 1), 0, none_res);
        add_row(make_vertex(32767, 0, 0, 0), 0, none_res);
        add_row(make_vertex(0, -32768, 0, 0), 0, none_res);
        add_row(make_vertex(0, 0, 32767, 0), 0, none_res);
        add_row(make_facet(0, 1, 2, 0), 0, none_res);
        add_row(make_facet(1, 2, 3, 0), 0, none_res);
        add_row(make_facet(0, 0, 1, 0), 0, none_res);
        // load after facets
        add_row(make_vertex(-32768, -32768, -32768, 0), 0, none_res);
        add_row(make_facet(4, 1, 3, 0), 0, none_res);
        add_row(make_facet(1, 2, 63, 0), 0, none_res);
        add_row(make_facet(0, 2, 3, 1), 0, none_res);
        // extreme spread
        add_row(make_vertex(-32768, -32768, -32768, 0), 0, none_res);
        add_row(make_vertex(32767, -32768, -32768, 0), 0, none_res);
        add_row(make_vertex(-32768, 32767, -32768, 0), 0, none_res);
        add_row(make_vertex(-32768, -32768, 32767, 0), 0, none_res);
        add_row(make_facet(1, 2, 3, 0), 0, none_res);
        add_row(make_facet(0, 1, 2, 1), 0, none_res);
        foreach (directed[i])
            send_item(directed[i].stim, directed[i].typed, directed[i].want);

        // store full: 66 loads, then facets
        for (k = 0; k < 66; k++)
            send_vertex_rand(32768);
        send_facet_rand(64, 0);
        send_item(make_facet(63, 62, 0, 1), 0, none_res);

        // random cells
        k = 0;
        cells = 0;
        while (k < 520)
        begin
            if (k > 420)
                drain_quiet = 1;
            nv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 64) : $urandom_range(3, 10);
            span = ($urandom_range(0, 3) == 0) ? 32768 : $urandom_range(1, 2000);
            for (int v = 0; v < nv; v++)
            begin
                send_vertex_rand(span);
                k++;
            end
            nf = $urandom_range(1, 6);
            for (int f = 0; f < nf; f++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_vertex_rand(span);
                    nv = (nv < 64) ? nv + 1 : nv;
                    k++;
                end
                send_facet_rand(nv, f == nf - 1);
                k++;
            end
            cells++;
        end
        item_valid <= 1'b0;
        stim_done = 1;
    end

    // receiver side stall, with one long hold-off
    initial
    begin
        int n;
        result_stall = 1'b0;
        hold_off = 0;
        @(posedge rst_n);
        repeat (40) @(posedge clk);
        while (!stim_done)
        begin
            if (!hold_off && volume_queue.size() > 0 && $urandom_range(0, 7) == 0)
            begin
                hold_off = 1;
                result_stall <= 1'b1;
                repeat (300) @(posedge clk);
                result_stall <= 1'b0;
                @(posedge clk);
            end
            else if (!drain_quiet && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 13);
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
                result_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else
            begin
                result_stall <= 1'b0;
                @(posedge clk);
            end
        end
        result_stall <= 1'b0;
    end

    // result checking
    always @(posedge clk)
    begin
        pvf_out_t want;
        bit typed;
        pvf_out_t tw;
        if (rst_n && result_valid && !result_stall)
        begin
            if (volume_queue.size() == 0)
            begin
                $display("%0t: unexpected result volume=%0d bad=%0b",
                    $time, result.cell_volume, result.bad_index);
                failures++;
            end
            else
            begin
                want = volume_queue.pop_front();
                typed = typed_queue.pop_front();
                tw = typed_want.pop_front();
                if (typed)
                    want = tw;
                if (result.cell_volume !== want.cell_volume)
                begin
                    $display("%0t: cell_volume expected %0d actual %0d",
                        $time, want.cell_volume, result.cell_volume);
                    failures++;
                end
                if (result.bad_index !== want.bad_index)
                begin
                    $display("%0t: bad_index expected %0b actual %0b",
                        $time, want.bad_index, result.bad_index);
                    failures++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // end of run
    initial
    begin
        wait (stim_done);
        while (volume_queue.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
